@@ src/pes_pkg.sv @@
// pes header parser package: phase codes, tags, error codes, field decode helpers
// no dependencies
package pes_pkg;

    localparam int TagW = 4;
    localparam int ValW = 33;
    localparam int ErrW = 4;

    typedef enum logic [4:0] {
        PH_WAIT     = 5'd0,
        PH_PREFIX   = 5'd1,
        PH_HDR      = 5'd2,
        PH_PTS      = 5'd3,
        PH_DTS      = 5'd4,
        PH_ESCR     = 5'd5,
        PH_RATE     = 5'd6,
        PH_TRICK    = 5'd7,
        PH_COPY     = 5'd8,
        PH_CRC      = 5'd9,
        PH_EXT      = 5'd10,
        PH_PRIV     = 5'd11,
        PH_PACKLEN  = 5'd12,
        PH_PACKDATA = 5'd13,
        PH_SEQ      = 5'd14,
        PH_PSTD     = 5'd15,
        PH_EXT2     = 5'd16,
        PH_IDEXT    = 5'd17,
        PH_STUFF    = 5'd18
    } phase_t;

    typedef enum logic [3:0] {
        TAG_ID = 4'd0, TAG_LEN = 4'd1, TAG_SCR = 4'd2, TAG_FLAGS = 4'd3,
        TAG_PTS = 4'd4, TAG_DTS = 4'd5, TAG_ESCR = 4'd6, TAG_RATE = 4'd7,
        TAG_TRICK = 4'd8, TAG_COPY = 4'd9, TAG_CRC = 4'd10, TAG_SEQ = 4'd11,
        TAG_PSTD = 4'd12, TAG_IDEXT = 4'd13, TAG_DONE = 4'd14, TAG_ERR = 4'd15
    } tag_t;

    typedef enum logic [3:0] {
        ERR_NONE = 4'd0, ERR_MORE = 4'd1, ERR_START = 4'd2, ERR_SCR = 4'd3,
        ERR_PTS = 4'd4, ERR_DTS = 4'd5, ERR_ESCR = 4'd6, ERR_RATE = 4'd7,
        ERR_COPY = 4'd8, ERR_SEQ = 4'd9, ERR_PSTD = 4'd10, ERR_EXT2 = 4'd11
    } err_t;

    typedef struct packed {
        logic [TagW-1:0] tag;
        logic [ValW-1:0] value;
        logic [ErrW-1:0] err;
        logic            last;
    } result_t;

    localparam int MaxRes = 3;

    // flag mask selecting a phase
    function automatic logic [7:0] sel_mask(input logic [4:0] p);
        logic [7:0] m;
        case (p)
            PH_PTS: m = 8'h80;     PH_DTS: m = 8'h40;    PH_ESCR: m = 8'h20;
            PH_RATE: m = 8'h10;    PH_TRICK: m = 8'h08;  PH_COPY: m = 8'h04;
            PH_CRC: m = 8'h02;     PH_EXT: m = 8'h01;    PH_PRIV: m = 8'h80;
            PH_PACKLEN: m = 8'h40; PH_SEQ: m = 8'h20;    PH_PSTD: m = 8'h10;
            PH_EXT2: m = 8'h01;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // byte count of a phase
    function automatic logic [7:0] sel_len(input logic [4:0] p);
        logic [7:0] l;
        case (p)
            PH_PTS, PH_DTS, PH_ESCR: l = 8'd5;
            PH_RATE: l = 8'd3;
            PH_CRC, PH_SEQ, PH_PSTD: l = 8'd2;
            PH_PRIV: l = 8'd16;
            PH_TRICK, PH_COPY, PH_EXT, PH_PACKLEN, PH_EXT2: l = 8'd1;
            default: l = 8'd0;
        endcase
        return l;
    endfunction

    function automatic logic [32:0] timestamp(input logic [39:0] a);
        return {a[35:33], a[31:24], a[23:17], a[15:8], a[7:1]};
    endfunction

    function automatic logic headerless(input logic [7:0] id);
        return (id == 8'hbc) || (id == 8'hbe) || (id == 8'hbf) || (id == 8'hf0)
            || (id == 8'hf1) || (id == 8'hf2) || (id == 8'hff) || (id == 8'hf8);
    endfunction

endpackage

@@ src/pes_header_parser.sv @@
// pes header parser top level: input register, parse core, result queue
// depends on pes_pkg, pes_core, pes_outq
//
// a byte accepted into the input register is parsed and its results are written into the result queue
// throughput: one byte per cycle while the result queue has room
// (up to three results per byte leave at one per cycle while out_ready is high)
// reset: asynchronous active low; parser waits for a start byte, queue empty
module pes_header_parser
    import pes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        start_req,
    input  logic        end_of_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  field_tag,
    output logic [32:0] field_value,
    output logic [3:0]  error_kind,
    output logic        last
);

    logic       v_reg;
    logic [7:0] byte_reg;
    logic       start_reg, eod_reg;
    logic       space;
    result_t [MaxRes-1:0] res;
    logic [1:0] res_cnt;
    result_t    q_res;

    // input stage advances when it is empty or the queue has room for its results
    assign in_ready = !v_reg || space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= byte_in;
            start_reg <= start_req;
            eod_reg   <= end_of_data;
        end
    end

    pes_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (v_reg && space),
        .byte_d  (byte_reg),
        .start_d (start_reg),
        .eod_d   (eod_reg),
        .res     (res),
        .res_cnt (res_cnt)
    );

    pes_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (v_reg && space),
        .push_res  (res),
        .push_cnt  (res_cnt),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (q_res)
    );

    assign field_tag   = q_res.tag;
    assign field_value = q_res.value;
    assign error_kind  = q_res.err;
    assign last        = q_res.last;

endmodule

@@ src/pes_core.sv @@
// pes header parser core: parse state and result generation for one registered byte
// depends on pes_pkg
module pes_core
    import pes_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       byte_d,
    input  logic             start_d,
    input  logic             eod_d,
    output result_t [MaxRes-1:0] res,
    output logic [1:0]       res_cnt
);

    logic [15:0] pos_reg, pos_next;
    logic [4:0]  ph_reg, ph_next;
    logic [7:0]  hflags_reg, hflags_next;
    logic [7:0]  xflags_reg, xflags_next;
    logic [39:0] acc_reg, acc_next;
    logic [8:0]  hlen_reg, hlen_next;
    logic [7:0]  sid_reg, sid_next;
    logic [7:0]  skip_reg, skip_next;
    logic        fin_reg, fin_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; ph_reg <= PH_WAIT; hflags_reg <= '0; xflags_reg <= '0;
            acc_reg <= '0; hlen_reg <= '0; sid_reg <= '0; skip_reg <= '0;
            fin_reg <= 1'b1;
        end
        else if (step)
        begin
            pos_reg <= pos_next; ph_reg <= ph_next; hflags_reg <= hflags_next;
            xflags_reg <= xflags_next; acc_reg <= acc_next; hlen_reg <= hlen_next;
            sid_reg <= sid_next; skip_reg <= skip_next; fin_reg <= fin_next;
        end
    end

    // next phase after a given one, using current flag sets
    function automatic logic [4:0] next_phase(input logic [4:0] from,
                                               input logic [7:0] hf,
                                               input logic [7:0] xf);
        logic [4:0] r;
        r = PH_STUFF;
        // scan downward so the lowest flagged phase wins
        for (int p = int'(PH_EXT2); p >= int'(PH_PTS); p--)
        begin
            if (p > int'(from) && p != int'(PH_PACKDATA)
                && (((p <= int'(PH_EXT)) ? hf : xf) & sel_mask(5'(p))) != 0)
                r = 5'(p);
        end
        return r;
    endfunction

    // per-byte parse
    always_comb
    begin
        logic [15:0] idx;
        logic [39:0] a;
        logic [7:0]  b, b0, f, sk;
        logic [2:0]  tm;
        logic [32:0] v;
        logic [15:0] len;
        logic [23:0] r24;
        logic        adv;
        logic [4:0]  adv_from;
        logic [4:0]  np;
        int          n;

        pos_next = pos_reg; ph_next = ph_reg; hflags_next = hflags_reg;
        xflags_next = xflags_reg; acc_next = acc_reg; hlen_next = hlen_reg;
        sid_next = sid_reg; skip_next = skip_reg; fin_next = fin_reg;
        res = '0;
        n = 0;
        idx = '0; a = '0; b = byte_d; b0 = '0; f = '0; sk = '0; tm = '0; v = '0;
        len = '0; r24 = '0; adv = 1'b0; adv_from = '0; np = '0;

        if (start_d)
        begin
            pos_next = '0; ph_next = PH_PREFIX; hflags_next = '0; xflags_next = '0;
            acc_next = '0; hlen_next = '0; sid_next = '0; skip_next = '0;
            fin_next = 1'b0;
        end

        if (!fin_next)
        begin
            idx = pos_next;
            if (pos_next != 16'hffff)
                pos_next = pos_next + 16'd1;
            case (ph_next)
                PH_PREFIX:
                begin
                    if (idx == 16'd3)
                        sid_next = b;
                    else
                        acc_next = {acc_next[31:0], b};
                    if (idx >= 16'd5)
                    begin
                        a = acc_next;
                        len = a[15:0];
                        if (a[39:16] != 24'h000001)
                        begin
                            res[n] = '{TAG_ERR, '0, ERR_START, 1'b1}; n++;
                            fin_next = 1'b1; ph_next = PH_WAIT;
                        end
                        else
                        begin
                            res[n] = '{TAG_ID, 33'(sid_next), ERR_NONE, 1'b0}; n++;
                            res[n] = '{TAG_LEN, (len != 0) ? 33'(len) + 33'd6 : '0,
                                       ERR_NONE, 1'b0}; n++;
                            if (headerless(sid_next))
                            begin
                                res[n] = '{TAG_DONE, 33'd6, ERR_NONE, 1'b1}; n++;
                                fin_next = 1'b1; ph_next = PH_WAIT;
                            end
                            else
                            begin
                                ph_next = PH_HDR; acc_next = '0;
                            end
                        end
                    end
                end
                PH_HDR:
                begin
                    if (idx == 16'd6)
                        acc_next = 40'(b);
                    else if (idx == 16'd7)
                        hflags_next = b;
                    else
                    begin
                        f = acc_next[7:0];
                        if (f[7:6] != 2'b10)
                        begin
                            res[n] = '{TAG_ERR, '0, ERR_SCR, 1'b1}; n++;
                            fin_next = 1'b1; ph_next = PH_WAIT;
                        end
                        else
                        begin
                            res[n] = '{TAG_SCR, 33'(f[5:4]), ERR_NONE, 1'b0}; n++;
                            res[n] = '{TAG_FLAGS, 33'(f[3:0]), ERR_NONE, 1'b0}; n++;
                            hlen_next = 9'(b) + 9'd9;
                            adv = 1'b1; adv_from = PH_HDR;
                        end
                    end
                end
                PH_PACKDATA:
                begin
                    sk = skip_next;
                    if (sk != 0)
                        sk = sk - 8'd1;
                    skip_next = sk;
                    if (sk == 0)
                    begin
                        adv = 1'b1; adv_from = PH_PACKDATA;
                    end
                end
                PH_IDEXT:
                begin
                    if (acc_next == 0)
                    begin
                        acc_next = 40'd1;
                        if (!b[7])
                        begin
                            res[n] = '{TAG_IDEXT, 33'(b), ERR_NONE, 1'b0}; n++;
                        end
                    end
                    sk = skip_next;
                    if (sk != 0)
                        sk = sk - 8'd1;
                    skip_next = sk;
                    if (sk == 0)
                        ph_next = PH_STUFF;
                end
                PH_STUFF: ;
                PH_PTS, PH_DTS, PH_ESCR, PH_RATE, PH_TRICK, PH_COPY, PH_CRC, PH_EXT,
                PH_PRIV, PH_PACKLEN, PH_SEQ, PH_PSTD, PH_EXT2:
                begin
                    acc_next = {acc_next[31:0], b};
                    a = acc_next;
                    b0 = a[15:8];
                    sk = skip_next;
                    if (sk != 0)
                        sk = sk - 8'd1;
                    skip_next = sk;
                    if (sk == 0)
                    begin
                        adv = 1'b1; adv_from = ph_next;
                        case (ph_next)
                            PH_PTS, PH_DTS, PH_ESCR:
                            begin
                                if (!a[32] || !a[16] || !a[0])
                                begin
                                    res[n] = '{TAG_ERR, '0, 4'(ph_next + 5'd1), 1'b1}; n++;
                                    fin_next = 1'b1; ph_next = PH_WAIT; adv = 1'b0;
                                end
                                else
                                begin
                                    res[n] = '{4'(ph_next + 5'd1), timestamp(a), ERR_NONE,
                                               1'b0}; n++;
                                end
                            end
                            PH_RATE:
                            begin
                                r24 = a[23:0];
                                if (!r24[23] || !r24[0])
                                begin
                                    res[n] = '{TAG_ERR, '0, ERR_RATE, 1'b1}; n++;
                                    fin_next = 1'b1; ph_next = PH_WAIT; adv = 1'b0;
                                end
                                else
                                begin
                                    v = 33'(r24[22:1]) * 33'd50;
                                    res[n] = '{TAG_RATE, v, ERR_NONE, 1'b0}; n++;
                                end
                            end
                            PH_TRICK:
                            begin
                                tm = b[7:5];
                                v = 33'(tm);
                                if (tm == 3'd0 || tm == 3'd3)
                                    v = v | 33'({b[1:0], b[2], b[4:3], 3'b000});
                                else if (tm == 3'd2)
                                    v = v | 33'({b[4:3], 3'b000});
                                else if (tm == 3'd1 || tm == 3'd4)
                                    v = v | 33'({b[4:0], 8'h00});
                                res[n] = '{TAG_TRICK, v, ERR_NONE, 1'b0}; n++;
                            end
                            PH_COPY:
                            begin
                                if (!b[7])
                                begin
                                    res[n] = '{TAG_ERR, '0, ERR_COPY, 1'b1}; n++;
                                    fin_next = 1'b1; ph_next = PH_WAIT; adv = 1'b0;
                                end
                                else
                                begin
                                    res[n] = '{TAG_COPY, 33'(b[6:0]), ERR_NONE, 1'b0}; n++;
                                end
                            end
                            PH_CRC:
                            begin
                                res[n] = '{TAG_CRC, 33'(a[15:0]), ERR_NONE, 1'b0}; n++;
                            end
                            PH_EXT:
                                xflags_next = b;
                            PH_PACKLEN:
                            begin
                                if (b != 0)
                                begin
                                    ph_next = PH_PACKDATA; skip_next = b; adv = 1'b0;
                                end
                                else
                                    adv_from = PH_PACKDATA;
                            end
                            PH_SEQ:
                            begin
                                if (!b0[7] || !b[7])
                                begin
                                    res[n] = '{TAG_ERR, '0, ERR_SEQ, 1'b1}; n++;
                                    fin_next = 1'b1; ph_next = PH_WAIT; adv = 1'b0;
                                end
                                else
                                begin
                                    res[n] = '{TAG_SEQ, 33'({b0[6:0], b[6:0]}), ERR_NONE,
                                               1'b0}; n++;
                                end
                            end
                            PH_PSTD:
                            begin
                                if (b0[7:6] != 2'b01)
                                begin
                                    res[n] = '{TAG_ERR, '0, ERR_PSTD, 1'b1}; n++;
                                    fin_next = 1'b1; ph_next = PH_WAIT; adv = 1'b0;
                                end
                                else
                                begin
                                    v = b0[5] ? {10'd0, a[12:0], 10'd0}
                                              : {13'd0, a[12:0], 7'd0};
                                    res[n] = '{TAG_PSTD, v, ERR_NONE, 1'b0}; n++;
                                end
                            end
                            PH_EXT2:
                            begin
                                adv = 1'b0;
                                if (!b[7])
                                begin
                                    res[n] = '{TAG_ERR, '0, ERR_EXT2, 1'b1}; n++;
                                    fin_next = 1'b1; ph_next = PH_WAIT;
                                end
                                else if (b[6:0] == 0)
                                    ph_next = PH_STUFF;
                                else
                                begin
                                    ph_next = PH_IDEXT; skip_next = {1'b0, b[6:0]};
                                    acc_next = '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default:
                    ph_next = PH_STUFF;
            endcase

            // move to the next flagged field
            if (adv)
            begin
                np = next_phase(adv_from, hflags_next, xflags_next);
                ph_next = np;
                if (np != PH_STUFF)
                begin
                    skip_next = sel_len(np);
                    acc_next = '0;
                end
            end

            // header complete
            if (!fin_next && ph_next == PH_STUFF && pos_next >= 16'(hlen_next))
            begin
                res[n] = '{TAG_DONE, 33'(hlen_next), ERR_NONE, 1'b1}; n++;
                fin_next = 1'b1; ph_next = PH_WAIT;
            end
            // data ran out
            if (!fin_next && eod_d)
            begin
                res[n] = '{TAG_ERR, '0, ERR_MORE, 1'b1}; n++;
                fin_next = 1'b1; ph_next = PH_WAIT;
            end
        end
        res_cnt = 2'(n);
    end

endmodule

@@ src/pes_outq.sv @@
// pes header parser result queue: holds up to eight results
// depends on pes_pkg
module pes_outq
    import pes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  result_t [MaxRes-1:0] push_res,
    input  logic [1:0]           push_cnt,
    output logic                 space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output result_t              out_res
);

    localparam int Depth = 8;
    result_t     mem_reg [Depth];
    logic [2:0]  rd_reg, rd_next, wr_reg, wr_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        pop;

    assign out_valid = (cnt_reg != 0);
    assign out_res   = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    // room for the worst case of one more transaction
    assign space     = (cnt_reg <= 4'(Depth - MaxRes));

    always_comb
    begin
        rd_next  = rd_reg + 3'(pop);
        wr_next  = wr_reg + (push ? 3'(push_cnt) : 3'd0);
        cnt_next = cnt_reg + (push ? 4'(push_cnt) : 4'd0) - 4'(pop);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < MaxRes; i++)
                if (2'(i) < push_cnt)
                    mem_reg[wr_reg + 3'(i)] <= push_res[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0; wr_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_next; wr_reg <= wr_next; cnt_reg <= cnt_next;
        end
    end

endmodule
